FILE: hdl/pire_pkg.sv
// Shared types, widths and constants for the rotated-ellipse point test.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package pire_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 32;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    // Fraction bits kept for cos/sin, and the widths that follow from them
    localparam int TRIG_FRAC  = ((58 - COORD_WIDTH) < 30) ? (58 - COORD_WIDTH) : 30;
    localparam int TRIG_SHIFT = 30 - TRIG_FRAC;
    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int TRIG_W     = TRIG_FRAC + 3;
    localparam int PROD_W     = TRIG_W + DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int ROT_W      = SUM_W + 1 - TRIG_FRAC;

    localparam int QUAD_W = 32;
    localparam logic [QUAD_W-1:0] ONE_Q24  = 32'd16777216;
    localparam logic [QUAD_W-1:0] QUAD_MAX = '1;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_SQ_MAJOR = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INV_SQ_MINOR = 8'd1;

    // Arctangent of 2^-step as a fraction of a 32-bit turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
        logic signed [CORDIC_W-1:0] a;
        case (step)
            0:       a = 32'sd536870912;
            1:       a = 32'sd316933406;
            2:       a = 32'sd167458907;
            3:       a = 32'sd85004756;
            4:       a = 32'sd42667331;
            5:       a = 32'sd21354465;
            6:       a = 32'sd10679838;
            7:       a = 32'sd5340245;
            8:       a = 32'sd2670163;
            9:       a = 32'sd1335087;
            10:      a = 32'sd667544;
            11:      a = 32'sd333772;
            12:      a = 32'sd166886;
            13:      a = 32'sd83443;
            14:      a = 32'sd41722;
            15:      a = 32'sd20861;
            16:      a = 32'sd10430;
            17:      a = 32'sd5215;
            18:      a = 32'sd2608;
            19:      a = 32'sd1304;
            20:      a = 32'sd652;
            21:      a = 32'sd326;
            22:      a = 32'sd163;
            23:      a = 32'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic signed [ANGLE_WIDTH-1:0] heading;
        logic signed [COORD_WIDTH-1:0] query_x;
        logic signed [COORD_WIDTH-1:0] query_y;
    } query_t;

    typedef struct packed {
        logic              inside_res;
        logic [QUAD_W-1:0] quad_value;
    } answer_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [1:0]               quadrant;
    } offset_t;

endpackage

FILE: hdl/pire_cordic_cell.sv
// One CORDIC rotation cell: a single micro-rotation per cycle while advance is high, offset rides along.
// Depends on pire_pkg.
module pire_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  pire_pkg::cordic_t in_vec,
    input  pire_pkg::offset_t in_ofs,
    output logic              out_valid,
    output pire_pkg::cordic_t out_vec,
    output pire_pkg::offset_t out_ofs
);

    localparam int W = pire_pkg::CORDIC_W;
    localparam logic signed [W-1:0] ATAN = pire_pkg::atan_turn(STEP);

    logic              valid_reg;
    pire_pkg::cordic_t vec_reg;
    pire_pkg::cordic_t vec_next;
    pire_pkg::offset_t ofs_reg;
    logic signed [W-1:0] x_in;
    logic signed [W-1:0] y_in;
    logic signed [W-1:0] z_in;
    logic signed [W-1:0] x_sh;
    logic signed [W-1:0] y_sh;

    always_comb
    begin
        x_in = in_vec.x;
        y_in = in_vec.y;
        z_in = in_vec.z;
        x_sh = x_in >>> STEP;
        y_sh = y_in >>> STEP;
        if (!z_in[W-1])
        begin
            vec_next.x = x_in - y_sh;
            vec_next.y = y_in + x_sh;
            vec_next.z = z_in - ATAN;
        end
        else
        begin
            vec_next.x = x_in + y_sh;
            vec_next.y = y_in - x_sh;
            vec_next.z = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec_reg <= vec_next;
            ofs_reg <= in_ofs;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_ofs   = ofs_reg;

endmodule

FILE: hdl/pire_quad_term.sv
// One term of the quadratic form: floor(m^2 * inv_sq / 2^32), capped, over four stages.
// Depends on pire_pkg.
module pire_quad_term (
    input  logic                                clk,
    input  logic                                advance,
    input  logic signed [pire_pkg::ROT_W-1:0]   value,
    input  logic [pire_pkg::QUAD_W-1:0]         inv_sq,
    output logic [pire_pkg::QUAD_W-1:0]         term
);

    localparam int RW    = pire_pkg::ROT_W;
    localparam int MAG_W = (RW > 33) ? RW : 33;

    logic [RW-1:0]    mag_u;
    logic [MAG_W-1:0] mag_wide;
    logic [31:0]      a_mag_reg;
    logic             a_sat_reg;
    logic [63:0]      b_sq_reg;
    logic             b_sat_reg;
    logic [63:0]      c_hi_reg;
    logic [63:0]      c_lo_reg;
    logic             c_sat_reg;
    logic [64:0]      t_sum;
    logic [pire_pkg::QUAD_W-1:0] d_term_next;
    logic [pire_pkg::QUAD_W-1:0] d_term_reg;

    // Magnitude; anything at or beyond 2^32 saturates the term
    always_comb
    begin
        mag_u    = value[RW-1] ? RW'(-value) : RW'(value);
        mag_wide = MAG_W'(mag_u);
    end

    always_comb
    begin
        t_sum = 65'(c_hi_reg) + 65'(c_lo_reg[63:32]);
        if (inv_sq == '0)
            d_term_next = '0;
        else if (c_sat_reg || (t_sum > 65'(pire_pkg::QUAD_MAX)))
            d_term_next = pire_pkg::QUAD_MAX;
        else
            d_term_next = t_sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_mag_reg  <= mag_wide[31:0];
            a_sat_reg  <= |mag_wide[MAG_W-1:32];
            b_sq_reg   <= 64'(a_mag_reg) * 64'(a_mag_reg);
            b_sat_reg  <= a_sat_reg;
            c_hi_reg   <= 64'(b_sq_reg[63:32]) * 64'(inv_sq);
            c_lo_reg   <= 64'(b_sq_reg[31:0]) * 64'(inv_sq);
            c_sat_reg  <= b_sat_reg;
            d_term_reg <= d_term_next;
        end
    end

    assign term = d_term_reg;

endmodule

FILE: hdl/point_in_rotated_ellipse_core.sv
// Point-in-rotated-ellipse test, top level: entry stage, CORDIC cell chain,
// rotation multipliers, two quadratic-term pipelines and the result register.
// Depends on pire_pkg, pire_cordic_cell and pire_quad_term.
//
// Usage:
//   query channel  (query_valid/query_ready/query): ellipse centre, heading and
//     the point to test, one transfer per query.
//   answer channel (answer_valid/answer_ready/answer): inside_res and the
//     saturated Q8.24 quadratic value, one transfer per query, in query order.
//   cfg channel    (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes
//     1/a^2, index 1 writes 1/b^2; other indexes are dropped. Always ready.
//     Write only while no query is in flight.
// Pipeline: entry stage, the 24 CORDIC cells (one micro-rotation each), the trig
//   rounding, multiply and rotate stages, the four-stage term pipelines and the
//   answer register; one query per cycle sustained while answers are accepted.
// Reset: both axis registers return to 1.0 (Q8.24) and the pipeline empties;
//   no clearing pass is needed.
// Stall: while an answer sits unaccepted the whole pipeline holds, and
//   query_ready follows answer_ready; bubbles move along and are not squeezed out.
module point_in_rotated_ellipse_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  query_valid,
    output logic                                  query_ready,
    input  pire_pkg::query_t                      query,
    output logic                                  answer_valid,
    input  logic                                  answer_ready,
    output pire_pkg::answer_t                     answer,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [pire_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [31:0]                           cfg_data
);

    localparam int STEPS  = pire_pkg::CORDIC_STEPS;
    localparam int CW     = pire_pkg::CORDIC_W;
    localparam int AW     = pire_pkg::ANGLE_WIDTH;
    localparam int XW     = pire_pkg::COORD_WIDTH;
    localparam int DW     = pire_pkg::DIFF_W;
    localparam int TW     = pire_pkg::TRIG_W;
    localparam int PW     = pire_pkg::PROD_W;
    localparam int SW     = pire_pkg::SUM_W;
    localparam int RW     = pire_pkg::ROT_W;
    localparam int QW     = pire_pkg::QUAD_W;
    localparam int TERM_STAGES = 4;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    localparam logic signed [CW+1:0] TRIG_HALF =
        (CW+2)'((64'd1 << pire_pkg::TRIG_SHIFT) >> 1);
    localparam logic signed [SW:0] ROT_HALF =
        (SW+1)'(64'd1 << (pire_pkg::TRIG_FRAC - 1));

    // Whole pipeline moves together; it only holds when the answer is stuck.
    logic answer_valid_reg;
    logic advance;
    assign advance     = !answer_valid_reg || answer_ready;
    assign query_ready = advance;

    // ---------------------------------------------------------------- config
    logic [QW-1:0] major_reg;
    logic [QW-1:0] minor_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg <= pire_pkg::ONE_Q24;
            minor_reg <= pire_pkg::ONE_Q24;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pire_pkg::CFG_INV_SQ_MAJOR: major_reg <= cfg_data;
                pire_pkg::CFG_INV_SQ_MINOR: minor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ entry stage
    // Form the offset and split the heading into quadrant and residual angle.
    logic signed [XW-1:0] qx;
    logic signed [XW-1:0] qy;
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic [31:0]          z32;
    pire_pkg::cordic_t    e_vec_next;
    pire_pkg::offset_t    e_ofs_next;
    logic                 e_valid_reg;
    pire_pkg::cordic_t    e_vec_reg;
    pire_pkg::offset_t    e_ofs_reg;

    always_comb
    begin
        qx  = query.query_x;
        qy  = query.query_y;
        cx  = query.center_x;
        cy  = query.center_y;
        z32 = {query.heading, {(32-AW){1'b0}}};
        e_ofs_next.dx       = {qx[XW-1], qx} - {cx[XW-1], cx};
        e_ofs_next.dy       = {qy[XW-1], qy} - {cy[XW-1], cy};
        e_ofs_next.quadrant = z32[31:30];
        e_vec_next.x        = pire_pkg::CORDIC_GAIN_Q30;
        e_vec_next.y        = '0;
        e_vec_next.z        = {{(CW-30){1'b0}}, z32[29:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (advance)
            e_valid_reg <= query_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_vec_reg <= e_vec_next;
            e_ofs_reg <= e_ofs_next;
        end
    end

    // ------------------------------------------------------------ CORDIC chain
    logic              cell_valid [STEPS+1];
    pire_pkg::cordic_t cell_vec   [STEPS+1];
    pire_pkg::offset_t cell_ofs   [STEPS+1];

    assign cell_valid[0] = e_valid_reg;
    assign cell_vec[0]   = e_vec_reg;
    assign cell_ofs[0]   = e_ofs_reg;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_cell
        pire_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (cell_valid[g]),
            .in_vec    (cell_vec[g]),
            .in_ofs    (cell_ofs[g]),
            .out_valid (cell_valid[g+1]),
            .out_vec   (cell_vec[g+1]),
            .out_ofs   (cell_ofs[g+1])
        );
    end

    // ------------------------------------------------------- trig round stage
    // Apply the quadrant exactly, then round half up to TRIG_FRAC bits.
    logic signed [CW-1:0]   fx;
    logic signed [CW-1:0]   fy;
    logic signed [CW-1:0]   c_full;
    logic signed [CW-1:0]   s_full;
    logic signed [CW+1:0]   c_wide;
    logic signed [CW+1:0]   s_wide;
    logic signed [CW+1:0]   c_shift;
    logic signed [CW+1:0]   s_shift;
    logic                   t_valid_reg;
    logic signed [TW-1:0]   t_c_reg;
    logic signed [TW-1:0]   t_s_reg;
    logic signed [DW-1:0]   t_dx_reg;
    logic signed [DW-1:0]   t_dy_reg;

    always_comb
    begin
        fx = cell_vec[STEPS].x;
        fy = cell_vec[STEPS].y;
        unique case (cell_ofs[STEPS].quadrant)
            QUAD_FIRST:
            begin
                c_full = fx;
                s_full = fy;
            end
            QUAD_SECOND:
            begin
                c_full = -fy;
                s_full = fx;
            end
            QUAD_THIRD:
            begin
                c_full = -fx;
                s_full = -fy;
            end
            QUAD_FOURTH:
            begin
                c_full = fy;
                s_full = -fx;
            end
            default:
            begin
                c_full = fx;
                s_full = fy;
            end
        endcase
        c_wide  = (CW+2)'(c_full) + TRIG_HALF;
        s_wide  = (CW+2)'(s_full) + TRIG_HALF;
        c_shift = c_wide >>> pire_pkg::TRIG_SHIFT;
        s_shift = s_wide >>> pire_pkg::TRIG_SHIFT;
    end

    // ------------------------------------------------------- multiply stage
    logic                 m_valid_reg;
    logic signed [PW-1:0] m_cdx_reg;
    logic signed [PW-1:0] m_sdy_reg;
    logic signed [PW-1:0] m_cdy_reg;
    logic signed [PW-1:0] m_sdx_reg;

    // --------------------------------------------------------- rotate stage
    logic signed [SW:0]   u_acc;
    logic signed [SW:0]   v_acc;
    logic signed [SW:0]   u_shift;
    logic signed [SW:0]   v_shift;
    logic                 r_valid_reg;
    logic signed [RW-1:0] r_u_reg;
    logic signed [RW-1:0] r_v_reg;

    always_comb
    begin
        u_acc   = (SW+1)'(m_cdx_reg) + (SW+1)'(m_sdy_reg) + ROT_HALF;
        v_acc   = (SW+1)'(m_cdy_reg) - (SW+1)'(m_sdx_reg) + ROT_HALF;
        u_shift = u_acc >>> pire_pkg::TRIG_FRAC;
        v_shift = v_acc >>> pire_pkg::TRIG_FRAC;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            t_valid_reg <= cell_valid[STEPS];
            m_valid_reg <= t_valid_reg;
            r_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_c_reg   <= c_shift[TW-1:0];
            t_s_reg   <= s_shift[TW-1:0];
            t_dx_reg  <= cell_ofs[STEPS].dx;
            t_dy_reg  <= cell_ofs[STEPS].dy;
            m_cdx_reg <= PW'(t_c_reg) * PW'(t_dx_reg);
            m_sdy_reg <= PW'(t_s_reg) * PW'(t_dy_reg);
            m_cdy_reg <= PW'(t_c_reg) * PW'(t_dy_reg);
            m_sdx_reg <= PW'(t_s_reg) * PW'(t_dx_reg);
            r_u_reg   <= u_shift[RW-1:0];
            r_v_reg   <= v_shift[RW-1:0];
        end
    end

    // ------------------------------------------------------ quadratic terms
    logic [QW-1:0] term_major;
    logic [QW-1:0] term_minor;
    logic          term_valid_reg [TERM_STAGES];

    pire_quad_term u_term_major (
        .clk     (clk),
        .advance (advance),
        .value   (r_u_reg),
        .inv_sq  (major_reg),
        .term    (term_major)
    );

    pire_quad_term u_term_minor (
        .clk     (clk),
        .advance (advance),
        .value   (r_v_reg),
        .inv_sq  (minor_reg),
        .term    (term_minor)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TERM_STAGES; i++)
                term_valid_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            term_valid_reg[0] <= r_valid_reg;
            for (int i = 1; i < TERM_STAGES; i++)
                term_valid_reg[i] <= term_valid_reg[i-1];
        end
    end

    // ------------------------------------------------------- answer register
    // Add the two terms, cap at the Q8.24 maximum and compare against one.
    logic [QW:0]       quad_sum;
    pire_pkg::answer_t answer_next;
    pire_pkg::answer_t answer_reg;

    always_comb
    begin
        quad_sum = (QW+1)'(term_major) + (QW+1)'(term_minor);
        if (quad_sum[QW])
            answer_next.quad_value = pire_pkg::QUAD_MAX;
        else
            answer_next.quad_value = quad_sum[QW-1:0];
        answer_next.inside_res = (answer_next.quad_value <= pire_pkg::ONE_Q24);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            answer_valid_reg <= 1'b0;
        else if (advance)
            answer_valid_reg <= term_valid_reg[TERM_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            answer_reg <= answer_next;
    end

    assign answer_valid = answer_valid_reg;
    assign answer       = answer_reg;

    // ------------------------------------------------------------ assertions
    a_inside_matches_value: assert property (@(posedge clk) disable iff (!rst_n)
        answer_valid |-> (answer.inside_res == (answer.quad_value <= pire_pkg::ONE_Q24)))
        else $error("inside flag disagrees with quadratic value");

    a_zero_axes_give_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (answer_valid && (major_reg == '0) && (minor_reg == '0))
            |-> (answer.quad_value == '0))
        else $error("nonzero value with both axis registers zero");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !answer_valid |-> query_ready)
        else $error("query stalled with no answer pending");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && term_valid_reg[TERM_STAGES-1]) |=> term_valid_reg[TERM_STAGES-1])
        else $error("item dropped from term pipeline during stall");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for point_in_rotated_ellipse_core: directed corner queries,
// then randomized ellipse/point queries under random back-pressure and idle gaps.
// Depends on pire_pkg (query_t, answer_t, register indexes) and the core itself.
module tb_top;

    typedef enum logic [1:0] {TURN_Q0, TURN_Q1, TURN_Q2, TURN_Q3} turn_quadrant_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             query_valid = 1'b0;
    logic                             query_ready;
    pire_pkg::query_t                 query = '0;
    logic                             answer_valid;
    logic                             answer_ready = 1'b0;
    pire_pkg::answer_t                answer;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [pire_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]                      cfg_data = '0;

    // Bench copy of the two axis registers, updated on each accepted cfg transfer to either of them
    logic [31:0] major_reg = pire_pkg::ONE_Q24;
    logic [31:0] minor_reg = pire_pkg::ONE_Q24;

    // Micro-rotation angles, fraction of a 32-bit turn
    longint atan_steps [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    pire_pkg::answer_t expected_answers [$];

    // Idle switches: cleared for stretches of back-to-back traffic
    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;

    int mismatches = 0;
    int sent_count = 0;
    int checked_count = 0;
    int inside_count = 0;
    int saturated_count = 0;
    int setting_count = 0;

    point_in_rotated_ellipse_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .answer_valid (answer_valid),
        .answer_ready (answer_ready),
        .answer       (answer),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Round half up, then drop n fraction bits (floor shift)
    function automatic longint round_half_up(input longint v, input int n);
        if (n == 0)
            return v;
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // floor(m^2 * reg / 2^32), capped at the Q8.24 maximum
    function automatic logic [31:0] scaled_square(input longint m, input logic [31:0] axis_reg);
        logic [63:0] mag;
        logic [95:0] prod;
        if (axis_reg == 0)
            return '0;
        mag = (m < 0) ? 64'(-m) : 64'(m);
        if (mag >= 64'h1_0000_0000)
            return pire_pkg::QUAD_MAX;
        prod = (96'(mag * mag) * 96'(axis_reg)) >> 32;
        if (prod > 96'(pire_pkg::QUAD_MAX))
            return pire_pkg::QUAD_MAX;
        return prod[31:0];
    endfunction

    function automatic pire_pkg::answer_t predict_answer(input pire_pkg::query_t q);
        longint            dx;
        longint            dy;
        logic [31:0]       z32;
        turn_quadrant_e    quadrant;
        longint            x;
        longint            y;
        longint            z;
        longint            nx;
        longint            c;
        longint            s;
        longint            u;
        longint            v;
        logic [31:0]       term_u;
        logic [31:0]       term_v;
        logic [32:0]       total;
        pire_pkg::answer_t a;
        int                i;

        dx = longint'(q.query_x) - longint'(q.center_x);
        dy = longint'(q.query_y) - longint'(q.center_y);

        // Scale the heading to a full 32-bit turn; top two bits pick the quadrant
        z32 = 32'({q.heading}) << (32 - pire_pkg::ANGLE_WIDTH);
        quadrant = turn_quadrant_e'(z32[31:30]);
        z = longint'({34'd0, z32[29:0]});
        x = longint'(pire_pkg::CORDIC_GAIN_Q30);
        y = 0;
        for (i = 0; i < pire_pkg::CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_steps[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_steps[i];
            end
            x = nx;
        end

        case (quadrant)
            TURN_Q1:
            begin
                c = -y;
                s = x;
            end
            TURN_Q2:
            begin
                c = -x;
                s = -y;
            end
            TURN_Q3:
            begin
                c = y;
                s = -x;
            end
            default:
            begin
                c = x;
                s = y;
            end
        endcase
        c = round_half_up(c, pire_pkg::TRIG_SHIFT);
        s = round_half_up(s, pire_pkg::TRIG_SHIFT);

        u = round_half_up(c * dx + s * dy, pire_pkg::TRIG_FRAC);
        v = round_half_up(c * dy - s * dx, pire_pkg::TRIG_FRAC);

        term_u = scaled_square(u, major_reg);
        term_v = scaled_square(v, minor_reg);
        total = {1'b0, term_u} + {1'b0, term_v};
        if (total > {1'b0, pire_pkg::QUAD_MAX})
            total = {1'b0, pire_pkg::QUAD_MAX};

        a.quad_value = total[31:0];
        a.inside_res = (total[31:0] <= pire_pkg::ONE_Q24);
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Answer side: random back-pressure and the field-by-field check
    // ------------------------------------------------------------------

    initial
    begin : answer_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = receiver_idle ? $urandom_range(0, 12) : 0;
            if (hold > 0)
            begin
                answer_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            answer_ready <= 1'b1;
            // hold ready until one answer transfers
            do @(posedge clk); while (!answer_valid);
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on answer %0d, %s: expected %0h, got %0h",
                     checked_count, what, want, got);
    endtask

    always @(posedge clk)
    begin : answer_check
        pire_pkg::answer_t want;
        if (rst_n && answer_valid && answer_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("answer with no query outstanding: inside=%0b quad=%0h",
                             answer.inside_res, answer.quad_value);
            end
            else
            begin
                want = expected_answers.pop_front();
                if (answer.inside_res !== want.inside_res)
                    note_mismatch("inside_res", 32'(want.inside_res), 32'(answer.inside_res));
                if (answer.quad_value !== want.quad_value)
                    note_mismatch("quad_value", want.quad_value, answer.quad_value);
                if (want.inside_res)
                    inside_count++;
                if (want.quad_value == pire_pkg::QUAD_MAX)
                    saturated_count++;
                checked_count++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Query side and configuration helpers
    // ------------------------------------------------------------------

    // Transfer one query after a random idle gap; keep valid high when gap is zero
    task automatic send_query(input pire_pkg::query_t q);
        int gap;
        gap = sender_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            query_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_valid <= 1'b1;
        query <= q;
        do @(posedge clk); while (!query_ready);
        expected_answers.push_back(predict_answer(q));
        sent_count++;
    endtask

    // Drop valid and hold off until every outstanding answer has transferred
    task automatic wait_all_answered();
        query_valid <= 1'b0;
        do @(posedge clk); while (expected_answers.size() != 0);
    endtask

    task automatic write_axis_reg(input logic [pire_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] data);
        wait_all_answered();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == pire_pkg::CFG_INV_SQ_MAJOR)
            major_reg = data;
        else if (idx == pire_pkg::CFG_INV_SQ_MINOR)
            minor_reg = data;
        setting_count++;
    endtask

    function automatic pire_pkg::query_t make_query(input longint cx, input longint cy,
                                                    input int hd, input longint qx,
                                                    input longint qy);
        pire_pkg::query_t q;
        q.center_x = 32'(cx);
        q.center_y = 32'(cy);
        q.heading  = 16'(hd);
        q.query_x  = 32'(qx);
        q.query_y  = 32'(qy);
        return q;
    endfunction

    // Mostly points near a random centre so the inside flag flips often; the rest are
    // far offsets and fully random fields
    function automatic pire_pkg::query_t random_query();
        pire_pkg::query_t q;
        int               span;
        int               mode;
        mode = $urandom_range(0, 9);
        q.center_x = $urandom;
        q.center_y = $urandom;
        q.heading  = 16'($urandom);
        if (mode <= 6)
        begin
            span = (mode <= 4) ? (1 << 18) : (1 << 24);
            q.query_x = q.center_x + 32'($urandom_range(0, 2 * span) - span);
            q.query_y = q.center_y + 32'($urandom_range(0, 2 * span) - span);
        end
        else
        begin
            q.query_x = $urandom;
            q.query_y = $urandom;
        end
        return q;
    endfunction

    function automatic logic [31:0] random_axis_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(1 << 20, 1 << 28));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values (1.0, 1.0): unit circle, heading extremes and the quadrant seams
    task automatic test_reset_circle();
        send_query(make_query(0, 0, 0, 0, 0));
        send_query(make_query(0, 0, 0, 65536, 0));
        send_query(make_query(0, 0, 0, 0, -65536));
        send_query(make_query(1000, -1000, -32768, 1000 + 46341, -1000 + 46341));
        send_query(make_query(0, 0, 32767, 65537, 0));
        send_query(make_query(0, 0, 16384, 30000, 50000));
        send_query(make_query(0, 0, -16384, -30000, 50000));
        send_query(make_query(0, 0, 8192, 65536, 65536));
        send_query(make_query(-5, 7, -1, 65535, 1));
    endtask

    // Full-range coordinates: offsets from zero up to 2^32 - 1, most of which saturate the quadratic value
    task automatic test_coordinate_extremes();
        send_query(make_query(-2147483648, -2147483648, 0, 2147483647, 2147483647));
        send_query(make_query(2147483647, -2147483648, 12345, -2147483648, 2147483647));
        send_query(make_query(2147483647, 2147483647, -32768, 2147483647, 2147483647));
        send_query(make_query(-2147483648, 0, 4096, -2147483648, 131072));
        send_query(make_query(0, 0, 0, 32'h7FFF_FFFF, 0));
    endtask

    // Zero and maximum registers, and writes to indexes past the two registers
    task automatic test_register_extremes();
        write_axis_reg(pire_pkg::CFG_INV_SQ_MAJOR, '0);
        send_query(make_query(0, 0, 0, 2147483647, 0));
        send_query(make_query(0, 0, 0, 0, 65536));
        write_axis_reg(pire_pkg::CFG_INV_SQ_MINOR, '0);
        send_query(make_query(-2147483648, -2147483648, 777, 2147483647, 2147483647));
        write_axis_reg(pire_pkg::CFG_INV_SQ_MAJOR, '1);
        write_axis_reg(pire_pkg::CFG_INV_SQ_MINOR, '1);
        send_query(make_query(0, 0, 0, 256, 0));
        send_query(make_query(0, 0, 0, 1, 1));
        send_query(make_query(0, 0, 100, 65536, 65536));
        // writes to unused indexes must leave both registers alone
        write_axis_reg(pire_pkg::CFG_INDEX_W'(pire_pkg::CFG_INV_SQ_MINOR + 1), 32'h1234_5678);
        write_axis_reg('1, '0);
        send_query(make_query(0, 0, 0, 300, 0));
        write_axis_reg(pire_pkg::CFG_INV_SQ_MAJOR, pire_pkg::ONE_Q24);
        write_axis_reg(pire_pkg::CFG_INV_SQ_MINOR, pire_pkg::ONE_Q24 >> 2);
        send_query(make_query(0, 0, 0, 65536, 131072));
    endtask

    // Random phases: new axis registers every phase, idle on or off per phase
    task automatic test_random_queries(input int total);
        int n;
        int phase_len;
        n = 0;
        while (n < total)
        begin
            write_axis_reg(pire_pkg::CFG_INV_SQ_MAJOR, random_axis_value());
            write_axis_reg(pire_pkg::CFG_INV_SQ_MINOR, random_axis_value());
            if ($urandom_range(0, 9) == 0)
                write_axis_reg(8'($urandom_range(pire_pkg::CFG_INV_SQ_MINOR + 1, 255)),
                               $urandom);
            sender_idle = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len)
            begin
                send_query(random_query());
                n++;
                // one full pause mid-run: let the pipeline empty before going on
                if (n == total / 2)
                    wait_all_answered();
            end
        end
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_circle();
        test_coordinate_extremes();
        test_register_extremes();
        test_random_queries(400);

        wait_all_answered();
        repeat (40) @(posedge clk);
        if (expected_answers.size() != 0)
        begin
            mismatches++;
            $display("%0d answers never arrived", expected_answers.size());
        end

        $display("Summary: %0d queries, %0d answers checked over %0d register writes",
                 sent_count, checked_count, setting_count);
        $display("         %0d answers inside, %0d saturated, %0d mismatches",
                 inside_count, saturated_count, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
